@@ sv/store_dma_request_sequencer_unit_macros.svh @@
// Assertion macros for the store DMA request sequencer unit.
`ifndef STORE_DMA_REQUEST_SEQUENCER_UNIT_MACROS_SVH
`define STORE_DMA_REQUEST_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SDRS_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sequencer check failed");

// Next-cycle implication, disabled in reset.
`define SDRS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sequencer check failed");

`endif

@@ sv/sdrs_pkg.sv @@
// Types, codes and counter helpers for the store DMA request sequencer.
`default_nettype none

package sdrs_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POOL_WINDOW_SIZE = 3'd0,
      CSR_POOL_OUT_ROWS    = 3'd1,
      CSR_POOL_OUT_COLS    = 3'd2,
      CSR_LINE_OUT_ROWS    = 3'd3,
      CSR_LINE_OUT_COLS    = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_WAIT_CMD = 4'b0001,
      ST_WAIT_DMA = 4'b0010,
      ST_SENDING  = 4'b0100,
      ST_POOLING  = 4'b1000
   } state_type;

   typedef struct packed {
      logic        head_valid;
      logic        head_is_config;
      logic        head_is_store;
      logic [7:0]  head_tag;
      logic        tracker_ready;
      logic [3:0]  tracker_new_id;
      logic        dma_ready;
      logic [7:0]  row_count;
      logic [7:0]  block_count;
      logic [15:0] line_row_count;
      logic [15:0] pooled_total_rows;
      logic [1:0]  store_mode;
   } req_type;

   typedef struct packed {
      logic        tracker_alloc_valid;
      logic [15:0] response_count;
      logic [7:0]  alloc_tag;
      logic        dma_request_valid;
      logic [3:0]  dma_request_id;
      logic        head_ready;
      logic [15:0] row_index;
      logic [7:0]  block_index;
      logic [7:0]  pooled_row_index;
      logic [7:0]  pooled_col_index;
      logic [7:0]  window_row_index;
      logic [7:0]  window_col_index;
   } rsp_type;

   // Increment and wrap to zero at the modulus; a zero modulus always wraps.
   function automatic logic [15:0] wrap_inc16(input logic [15:0] value,
                                              input logic [15:0] modulus);
      logic [16:0] sum;
      sum = {1'b0, value} + 17'd1;
      if (modulus == 16'd0 || sum >= {1'b0, modulus}) begin
         return 16'd0;
      end
      return sum[15:0];
   endfunction

   function automatic logic [7:0] wrap_inc8(input logic [7:0] value,
                                            input logic [7:0] modulus);
      logic [8:0] sum;
      sum = {1'b0, value} + 9'd1;
      if (modulus == 8'd0 || sum >= {1'b0, modulus}) begin
         return 8'd0;
      end
      return sum[7:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/store_dma_request_sequencer_unit.sv @@
// Store DMA request sequencer: command FSM, tracker allocation and row, block and pooling counters.
// An accepted item is held in the input register, then passes to the result register that
// drives rsp_valid once that register is empty or being taken with rsp_ready high.
// Throughput: one item per cycle, one pass of FSM and counter logic between the input and
// result registers; with the result held, input stalls once both registers are full.
// Reset (synchronous, active high) clears FSM, tracker id, counters, config and valids.
`default_nettype none

`include "store_dma_request_sequencer_unit_macros.svh"

module store_dma_request_sequencer_unit
   import sdrs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,

   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_head_valid,
   input  wire logic                       req_head_is_config,
   input  wire logic                       req_head_is_store,
   input  wire logic [7:0]                 req_head_tag,
   input  wire logic                       req_tracker_ready,
   input  wire logic [3:0]                 req_tracker_new_id,
   input  wire logic                       req_dma_ready,
   input  wire logic [7:0]                 req_row_count,
   input  wire logic [7:0]                 req_block_count,
   input  wire logic [15:0]                req_line_row_count,
   input  wire logic [15:0]                req_pooled_total_rows,
   input  wire logic [1:0]                 req_store_mode,

   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_tracker_alloc_valid,
   output logic [15:0]                     rsp_response_count,
   output logic [7:0]                      rsp_alloc_tag,
   output logic                            rsp_dma_request_valid,
   output logic [3:0]                      rsp_dma_request_id,
   output logic                            rsp_head_ready,
   output logic [15:0]                     rsp_row_index,
   output logic [7:0]                      rsp_block_index,
   output logic [7:0]                      rsp_pooled_row_index,
   output logic [7:0]                      rsp_pooled_col_index,
   output logic [7:0]                      rsp_window_row_index,
   output logic [7:0]                      rsp_window_col_index
);

   logic [7:0]  pool_window_size_ff;
   logic [7:0]  pool_out_rows_ff;
   logic [7:0]  pool_out_cols_ff;
   logic [7:0]  line_out_rows_ff;
   logic [7:0]  line_out_cols_ff;

   logic        in_valid_ff;
   req_type     in_ff;
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic        advance;

   state_type   state_ff, state_in;
   logic [3:0]  active_id_ff, active_id_in;
   logic [15:0] row_ctr_ff, row_ctr_in;
   logic [7:0]  block_ctr_ff, block_ctr_in;
   logic [7:0]  pooled_row_ctr_ff, pooled_row_ctr_in;
   logic [7:0]  pooled_col_ctr_ff, pooled_col_ctr_in;
   logic [7:0]  window_row_ctr_ff, window_row_ctr_in;
   logic [7:0]  window_col_ctr_ff, window_col_ctr_in;

   logic        pooling;
   logic        line1d;
   logic        head_store;
   logic        alloc;
   logic        alloc_now;
   logic [15:0] product;
   logic [15:0] resp_count;
   logic        req_c;
   logic        fire;
   logic        pop_now;
   logic [15:0] eff_rows;
   logic        last_blk;
   logic        row_end;
   logic        win_col_last;
   logic        win_row_last;
   logic        pool_col_last;
   logic        line_col_last;
   logic        pool_idle;
   logic        final_pos;
   rsp_type     result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_window_size_ff <= '0;
         pool_out_rows_ff    <= '0;
         pool_out_cols_ff    <= '0;
         line_out_rows_ff    <= '0;
         line_out_cols_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POOL_WINDOW_SIZE: pool_window_size_ff <= csr_wdata;
            CSR_POOL_OUT_ROWS:    pool_out_rows_ff    <= csr_wdata;
            CSR_POOL_OUT_COLS:    pool_out_cols_ff    <= csr_wdata;
            CSR_LINE_OUT_ROWS:    line_out_rows_ff    <= csr_wdata;
            CSR_LINE_OUT_COLS:    line_out_cols_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // per-item decode
   always_comb begin
      pooling    = in_ff.store_mode[1];
      line1d     = in_ff.store_mode[0];
      head_store = in_ff.head_valid && in_ff.head_is_store;
      alloc      = (state_ff == ST_WAIT_CMD) && head_store;
      alloc_now  = alloc && in_ff.tracker_ready;
      product    = {8'd0, in_ff.row_count} * {8'd0, in_ff.block_count};
      resp_count = pooling ? in_ff.pooled_total_rows
                 : (line1d ? in_ff.line_row_count : product);
      req_c = alloc_now || (state_ff == ST_WAIT_DMA)
           || ((state_ff == ST_SENDING) && (block_ctr_ff != 8'd0 || row_ctr_ff != 16'd0))
           || ((state_ff == ST_POOLING) && (window_col_ctr_ff != 8'd0
               || window_row_ctr_ff != 8'd0 || pooled_col_ctr_ff != 8'd0
               || pooled_row_ctr_ff != 8'd0));
      fire = req_c && in_ff.dma_ready;

      eff_rows = line1d ? in_ff.line_row_count : {8'd0, in_ff.row_count};
      last_blk = (in_ff.block_count != 8'd0) && (block_ctr_ff == in_ff.block_count - 8'd1);
      row_end  = (eff_rows != 16'd0) && (row_ctr_ff == eff_rows - 16'd1);
      win_col_last  = (pool_window_size_ff != 8'd0)
                   && (window_col_ctr_ff == pool_window_size_ff - 8'd1);
      win_row_last  = (pool_window_size_ff != 8'd0)
                   && (window_row_ctr_ff == pool_window_size_ff - 8'd1);
      pool_col_last = (pool_out_cols_ff != 8'd0)
                   && (pooled_col_ctr_ff == pool_out_cols_ff - 8'd1);
      line_col_last = (line_out_cols_ff != 8'd0)
                   && (pooled_col_ctr_ff == line_out_cols_ff - 8'd1);
      pool_idle = (pooled_row_ctr_ff == 8'd0) && (pooled_col_ctr_ff == 8'd0)
               && (window_row_ctr_ff == 8'd0) && (window_col_ctr_ff == 8'd0);
      final_pos = win_col_last && win_row_last && pool_col_last
               && (pool_out_rows_ff != 8'd0)
               && (pooled_row_ctr_ff == pool_out_rows_ff - 8'd1);
   end

   // FSM and counters
   always_comb begin
      state_in          = state_ff;
      active_id_in      = active_id_ff;
      row_ctr_in        = row_ctr_ff;
      block_ctr_in      = block_ctr_ff;
      pooled_row_ctr_in = pooled_row_ctr_ff;
      pooled_col_ctr_in = pooled_col_ctr_ff;
      window_row_ctr_in = window_row_ctr_ff;
      window_col_ctr_in = window_col_ctr_ff;
      pop_now           = 1'b0;

      case (state_ff)
         ST_WAIT_CMD: begin
            if (in_ff.head_valid) begin
               if (in_ff.head_is_config) begin
                  pop_now = 1'b1;
               end else if (in_ff.head_is_store && in_ff.tracker_ready) begin
                  active_id_in = in_ff.tracker_new_id;
                  if (fire) begin
                     state_in = pooling ? ST_POOLING : ST_SENDING;
                  end else begin
                     state_in = ST_WAIT_DMA;
                  end
               end
            end
         end
         ST_WAIT_DMA: begin
            if (fire) begin
               state_in = pooling ? ST_POOLING : ST_SENDING;
            end
         end
         ST_SENDING: begin
            if ((last_blk && row_end && fire)
                || (block_ctr_ff == 8'd0 && row_ctr_ff == 16'd0)) begin
               state_in = ST_WAIT_CMD;
               pop_now  = 1'b1;
            end
         end
         ST_POOLING: begin
            if (pool_idle || (final_pos && fire)) begin
               state_in = ST_WAIT_CMD;
               pop_now  = 1'b1;
            end
         end
         default: begin
            state_in = ST_WAIT_CMD;
         end
      endcase

      if (fire) begin
         if (!pooling) begin
            if (line1d) begin
               pooled_col_ctr_in = wrap_inc8(pooled_col_ctr_ff, line_out_cols_ff);
               if (line_col_last) begin
                  pooled_row_ctr_in = wrap_inc8(pooled_row_ctr_ff, line_out_rows_ff);
               end
               row_ctr_in = wrap_inc16(row_ctr_ff, in_ff.line_row_count);
            end else if (last_blk) begin
               row_ctr_in = wrap_inc16(row_ctr_ff, {8'd0, in_ff.row_count});
            end
            block_ctr_in = wrap_inc8(block_ctr_ff, in_ff.block_count);
         end else begin
            window_col_ctr_in = wrap_inc8(window_col_ctr_ff, pool_window_size_ff);
            if (win_col_last) begin
               window_row_ctr_in = wrap_inc8(window_row_ctr_ff, pool_window_size_ff);
               if (win_row_last) begin
                  pooled_col_ctr_in = wrap_inc8(pooled_col_ctr_ff, pool_out_cols_ff);
                  if (pool_col_last) begin
                     pooled_row_ctr_in = wrap_inc8(pooled_row_ctr_ff, pool_out_rows_ff);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      result.tracker_alloc_valid = alloc;
      result.response_count      = resp_count;
      result.alloc_tag           = head_store ? in_ff.head_tag : 8'd0;
      result.dma_request_valid   = req_c;
      result.dma_request_id      = alloc_now ? in_ff.tracker_new_id : active_id_ff;
      result.head_ready          = pop_now;
      result.row_index           = row_ctr_ff;
      result.block_index         = block_ctr_ff;
      result.pooled_row_index    = pooled_row_ctr_ff;
      result.pooled_col_index    = pooled_col_ctr_ff;
      result.window_row_index    = window_row_ctr_ff;
      result.window_col_index    = window_col_ctr_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         state_ff          <= ST_WAIT_CMD;
         active_id_ff      <= '0;
         row_ctr_ff        <= '0;
         block_ctr_ff      <= '0;
         pooled_row_ctr_ff <= '0;
         pooled_col_ctr_ff <= '0;
         window_row_ctr_ff <= '0;
         window_col_ctr_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff      <= 1'b1;
            state_ff          <= state_in;
            active_id_ff      <= active_id_in;
            row_ctr_ff        <= row_ctr_in;
            block_ctr_ff      <= block_ctr_in;
            pooled_row_ctr_ff <= pooled_row_ctr_in;
            pooled_col_ctr_ff <= pooled_col_ctr_in;
            window_row_ctr_ff <= window_row_ctr_in;
            window_col_ctr_ff <= window_col_ctr_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.head_valid        <= req_head_valid;
         in_ff.head_is_config    <= req_head_is_config;
         in_ff.head_is_store     <= req_head_is_store;
         in_ff.head_tag          <= req_head_tag;
         in_ff.tracker_ready     <= req_tracker_ready;
         in_ff.tracker_new_id    <= req_tracker_new_id;
         in_ff.dma_ready         <= req_dma_ready;
         in_ff.row_count         <= req_row_count;
         in_ff.block_count       <= req_block_count;
         in_ff.line_row_count    <= req_line_row_count;
         in_ff.pooled_total_rows <= req_pooled_total_rows;
         in_ff.store_mode        <= req_store_mode;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_tracker_alloc_valid = out_ff.tracker_alloc_valid;
   assign rsp_response_count      = out_ff.response_count;
   assign rsp_alloc_tag           = out_ff.alloc_tag;
   assign rsp_dma_request_valid   = out_ff.dma_request_valid;
   assign rsp_dma_request_id      = out_ff.dma_request_id;
   assign rsp_head_ready          = out_ff.head_ready;
   assign rsp_row_index           = out_ff.row_index;
   assign rsp_block_index         = out_ff.block_index;
   assign rsp_pooled_row_index    = out_ff.pooled_row_index;
   assign rsp_pooled_col_index    = out_ff.pooled_col_index;
   assign rsp_window_row_index    = out_ff.window_row_index;
   assign rsp_window_col_index    = out_ff.window_col_index;

   `SDRS_ASSERT_SAME(a_hold_when_full, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_ready, !req_ready)
   `SDRS_ASSERT_NEXT(a_alloc_only_idle, clock, reset,
      advance && state_ff != ST_WAIT_CMD, !rsp_tracker_alloc_valid)
   `SDRS_ASSERT_NEXT(a_done_returns_idle, clock, reset,
      advance && pop_now && state_ff != ST_WAIT_CMD, state_ff == ST_WAIT_CMD)

endmodule

`default_nettype wire
